// File: src/bmrl_pkg.sv
// Shared types and constants for the block mean ring logger.
// Used by bmrl_front, bmrl_back and the top module; depends on nothing else.
`default_nettype none

package bmrl_pkg;

  // Fixed field widths.
  localparam int IDX_W      = 10;
  localparam int TIME_W     = 32;
  localparam int SPM_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Largest number of samples averaged into one mean.
  localparam int MAX_BLOCK = 1024;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_LOG_DEPTH    = 1024;
  localparam int DEFAULT_SAMPLE_WIDTH = 24;

  // Register reset values.
  localparam logic [SPM_W-1:0]  SPM_RESET        = SPM_W'(1);
  localparam logic [IDX_W-1:0]  LAST_INDEX_RESET = IDX_W'(999);
  localparam logic [TIME_W-1:0] START_MS_RESET   = '0;

  // Input item kinds as coded on the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_READ   = 2'd1,
    MODE_STEP   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  // Work kinds after classification in the front.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_STEP   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SAMPLES_PER_MEAN = 2'd0,
    CFG_LAST_INDEX       = 2'd1,
    CFG_START_AFTER_MS   = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [SPM_W-1:0]  samples_per_mean;
    logic [IDX_W-1:0]  last_index;
    logic [TIME_W-1:0] start_after_ms;
  } cfg_t;

  // One classified command; the sample travels beside it.
  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  index;
    logic [TIME_W-1:0] stamp;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/bmrl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none

module bmrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]               wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr_i,
  output      logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/bmrl_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on bmrl_pkg.
`default_nettype none

module bmrl_front #(
  parameter int SAMPLE_WIDTH = bmrl_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic [bmrl_pkg::MODE_W-1:0]        mode_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_i,
  input  wire logic [bmrl_pkg::TIME_W-1:0]        now_ms_i,
  input  wire logic [bmrl_pkg::TIME_W-1:0]        elapsed_ms_i,
  input  wire logic [bmrl_pkg::IDX_W-1:0]         index_i,
  input  wire logic [bmrl_pkg::TIME_W-1:0]        start_after_ms_i,
  output      logic                               cmd_valid_o,
  output      bmrl_pkg::cmd_t                     cmd_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     cmd_sample_o,
  input  wire logic                               cmd_pop_i
);

  localparam int QD   = bmrl_pkg::QUEUE_DEPTH;
  localparam int QAW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNTW = $clog2(QD + 1);

  bmrl_pkg::cmd_t              cmd_q [QD];
  logic signed [SAMPLE_WIDTH-1:0] smp_q [QD];
  logic [QAW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]             cnt_q, cnt_d;
  bmrl_pkg::cmd_t              cmd_new;
  logic                        push;

  assign in_stall_o = (cnt_q == CNTW'(QD));
  assign push       = in_valid_i && !in_stall_o;

  // Classify the incoming transaction; early samples only report status.
  always_comb begin
    cmd_new.index = index_i;
    cmd_new.stamp = elapsed_ms_i;
    case (mode_i)
      bmrl_pkg::MODE_SAMPLE: begin
        cmd_new.op = (now_ms_i < start_after_ms_i) ? bmrl_pkg::OP_STATUS
                                                   : bmrl_pkg::OP_SAMPLE;
      end
      bmrl_pkg::MODE_READ: cmd_new.op = bmrl_pkg::OP_READ;
      bmrl_pkg::MODE_STEP: cmd_new.op = bmrl_pkg::OP_STEP;
      default:             cmd_new.op = bmrl_pkg::OP_STATUS;
    endcase
  end

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    case ({push, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + CNTW'(1);
      2'b01:   cnt_d = cnt_q - CNTW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= cmd_new;
      smp_q[wr_ptr_q] <= sample_i;
    end
  end

  assign cmd_valid_o  = (cnt_q != '0);
  assign cmd_o        = cmd_q[rd_ptr_q];
  assign cmd_sample_o = smp_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: src/bmrl_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; used by bmrl_back for the block mean.
`default_nettype none

module bmrl_div #(
  parameter int DW = 34,
  parameter int VW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output      logic          done_o,
  output      logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(DW);
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// File: src/bmrl_back.sv
// Back end: executes queued commands, keeps the block sum, statistics and
// ring pointers, owns the log RAM and the output register.
// Depends on bmrl_pkg, bmrl_div and bmrl_ram.
`default_nettype none

module bmrl_back #(
  parameter int LOG_DEPTH    = bmrl_pkg::DEFAULT_LOG_DEPTH,
  parameter int SAMPLE_WIDTH = bmrl_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bmrl_pkg::cfg_t                     cfg_i,
  input  wire logic                               cmd_valid_i,
  input  wire bmrl_pkg::cmd_t                     cmd_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     cmd_sample_i,
  output      logic                               cmd_pop_o,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic                               logged_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     mean_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     lowest_mean_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     highest_mean_o,
  output      logic [bmrl_pkg::IDX_W-1:0]         write_index_o,
  output      logic                               ring_full_o,
  output      logic [bmrl_pkg::IDX_W-1:0]         oldest_index_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     read_value_o,
  output      logic [bmrl_pkg::TIME_W-1:0]        read_time_o,
  output      logic [bmrl_pkg::IDX_W-1:0]         prev_index_o,
  output      logic                               prev_none_o
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int IDX_W  = bmrl_pkg::IDX_W;
  localparam int TIME_W = bmrl_pkg::TIME_W;
  localparam int SPM_W  = bmrl_pkg::SPM_W;
  localparam int AW     = $clog2(LOG_DEPTH);
  localparam int SUM_W  = SW + $clog2(bmrl_pkg::MAX_BLOCK) + 1;
  localparam int DW     = SUM_W - 1;
  localparam int HW_W   = IDX_W + 1;
  localparam int RAM_W  = SW + TIME_W;

  localparam logic signed [SW-1:0] S_MAX   = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN   = {1'b1, {(SW - 1){1'b0}}};
  localparam logic [DW-1:0]        POS_LIM = {{(DW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic [DW-1:0]        NEG_LIM = {{(DW - SW){1'b0}}, 1'b1, {(SW - 1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_LOG  = 5'b01000,
    ST_READ = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic signed [SUM_W-1:0] sum_q, sum_d, sum_inc, sum_neg;
  logic [SUM_W-1:0]      sum_abs;
  logic [SPM_W-1:0]      count_q, count_d, count_inc;
  logic signed [SW-1:0]  min_q, min_d, max_q, max_d, mean_q, mean_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d, oldest_q, oldest_d;
  logic                  full_q, full_d;
  logic [HW_W-1:0]       hw_q, hw_d, ptr_inc;
  logic                  wrap;
  logic [TIME_W-1:0]     stamp_q, stamp_d;
  logic                  hit_q, hit_d;
  logic signed [SW-1:0]  calc_q, calc_d, sat;
  logic [SPM_W-1:0]      n_eff;
  logic [IDX_W-1:0]      last_eff;
  logic                  blk_done;
  logic                  pop, fin, div_start, div_done, commit;
  logic [DW-1:0]         quot;
  logic [SW-1:0]         quot_lo, quot_neg;
  logic [RAM_W-1:0]      ram_rdata;

  // Output register contents.
  logic                  out_valid_q;
  logic                  logged_q, logged_d;
  logic signed [SW-1:0]  rval_q, rval_d;
  logic [TIME_W-1:0]     rtime_q, rtime_d;
  logic [IDX_W-1:0]      pidx_q, pidx_d;
  logic                  pnone_q, pnone_d;
  logic signed [SW-1:0]  mean_out_q, min_out_q, max_out_q;
  logic [IDX_W-1:0]      ptr_out_q, oldest_out_q;
  logic                  full_out_q;

  // Effective block length and ring end after clamping.
  always_comb begin
    if (cfg_i.samples_per_mean == '0) begin
      n_eff = SPM_W'(1);
    end else if (cfg_i.samples_per_mean > SPM_W'(bmrl_pkg::MAX_BLOCK)) begin
      n_eff = SPM_W'(bmrl_pkg::MAX_BLOCK);
    end else begin
      n_eff = cfg_i.samples_per_mean;
    end
  end

  assign last_eff = (32'(cfg_i.last_index) >= 32'(LOG_DEPTH)) ? IDX_W'(LOG_DEPTH - 1)
                                                               : cfg_i.last_index;

  // Running sum and count for the next sample.
  assign sum_inc   = sum_q + SUM_W'(cmd_sample_i);
  assign count_inc = count_q + SPM_W'(1);
  assign blk_done  = (count_inc >= n_eff);

  // Magnitude of the block sum for the divider.
  assign sum_neg = -sum_q;
  assign sum_abs = sum_q[SUM_W-1] ? sum_neg : sum_q;

  bmrl_div #(
    .DW (DW),
    .VW (SPM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs[DW-1:0]),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Restore the sign and saturate the quotient to the sample range.
  assign quot_lo  = quot[SW-1:0];
  assign quot_neg = -quot_lo;
  always_comb begin
    if (sum_q[SUM_W-1]) begin
      sat = (quot > NEG_LIM) ? S_MIN : $signed(quot_neg);
    end else begin
      sat = (quot > POS_LIM) ? S_MAX : $signed(quot_lo);
    end
  end

  assign pop = (state_q == ST_IDLE) && cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = pop;

  // Command sequencer.
  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    count_d   = count_q;
    stamp_d   = stamp_q;
    hit_d     = hit_q;
    calc_d    = calc_q;
    fin       = 1'b0;
    div_start = 1'b0;
    logged_d  = 1'b0;
    rval_d    = '0;
    rtime_d   = '0;
    pidx_d    = '0;
    pnone_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (cmd_i.op)
            bmrl_pkg::OP_SAMPLE: begin
              sum_d   = sum_inc;
              count_d = count_inc;
              stamp_d = cmd_i.stamp;
              if (blk_done) begin
                state_d = ST_PREP;
              end else begin
                fin = 1'b1;
              end
            end
            bmrl_pkg::OP_READ: begin
              hit_d   = ({1'b0, cmd_i.index} < hw_q);
              state_d = ST_READ;
            end
            bmrl_pkg::OP_STEP: begin
              fin = 1'b1;
              if (cmd_i.index != '0) begin
                pidx_d = cmd_i.index - IDX_W'(1);
              end else if (full_q) begin
                pidx_d = last_eff;
              end else begin
                pnone_d = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          calc_d  = sat;
          state_d = ST_LOG;
        end
      end
      ST_LOG: begin
        fin      = 1'b1;
        logged_d = 1'b1;
        sum_d    = '0;
        count_d  = '0;
        state_d  = ST_IDLE;
      end
      ST_READ: begin
        fin     = 1'b1;
        rval_d  = hit_q ? $signed(ram_rdata[RAM_W-1:TIME_W]) : S_MAX;
        rtime_d = hit_q ? ram_rdata[TIME_W-1:0] : '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Statistics and ring pointers advance when a mean is logged.
  assign commit  = (state_q == ST_LOG);
  assign ptr_inc = {1'b0, ptr_q} + HW_W'(1);
  assign wrap    = (ptr_inc > {1'b0, last_eff});

  always_comb begin
    mean_d   = mean_q;
    min_d    = min_q;
    max_d    = max_q;
    ptr_d    = ptr_q;
    full_d   = full_q;
    oldest_d = oldest_q;
    hw_d     = hw_q;
    if (commit) begin
      mean_d = calc_q;
      if (calc_q < min_q) begin
        min_d = calc_q;
      end
      if (calc_q > max_q) begin
        max_d = calc_q;
      end
      ptr_d  = wrap ? '0 : ptr_inc[IDX_W-1:0];
      full_d = full_q || wrap;
      if (full_d) begin
        oldest_d = (ptr_d == '0) ? last_eff : ptr_d - IDX_W'(1);
      end else begin
        oldest_d = '0;
      end
      // Entries are written in order from zero, so a high-water mark tells
      // which ones hold data.
      if (ptr_inc > hw_q) begin
        hw_d = ptr_inc;
      end
    end
  end

  bmrl_ram #(
    .WIDTH (RAM_W),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (AW'(ptr_q)),
    .wdata_i ({calc_q, stamp_q}),
    .raddr_i (AW'(cmd_i.index)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      mean_q      <= '0;
      min_q       <= S_MAX;
      max_q       <= S_MIN;
      ptr_q       <= '0;
      full_q      <= 1'b0;
      oldest_q    <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      mean_q   <= mean_d;
      min_q    <= min_d;
      max_q    <= max_d;
      ptr_q    <= ptr_d;
      full_q   <= full_d;
      oldest_q <= oldest_d;
      hw_q     <= hw_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    hit_q   <= hit_d;
    calc_q  <= calc_d;
    if (fin) begin
      logged_q     <= logged_d;
      rval_q       <= rval_d;
      rtime_q      <= rtime_d;
      pidx_q       <= pidx_d;
      pnone_q      <= pnone_d;
      mean_out_q   <= mean_d;
      min_out_q    <= min_d;
      max_out_q    <= max_d;
      ptr_out_q    <= ptr_d;
      full_out_q   <= full_d;
      oldest_out_q <= oldest_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign logged_o       = logged_q;
  assign mean_o         = mean_out_q;
  assign lowest_mean_o  = min_out_q;
  assign highest_mean_o = max_out_q;
  assign write_index_o  = ptr_out_q;
  assign ring_full_o    = full_out_q;
  assign oldest_index_o = oldest_out_q;
  assign read_value_o   = rval_q;
  assign read_time_o    = rtime_q;
  assign prev_index_o   = pidx_q;
  assign prev_none_o    = pnone_q;

endmodule

`default_nettype wire

// File: src/block_mean_ring_logger.sv
// Block mean ring logger: averages samples in blocks and logs each mean with
// a time stamp into a ring. Depends on bmrl_pkg, bmrl_front and bmrl_back.
//
// Usage: input transactions (mode, sample, now_ms, elapsed_ms, index) are
// taken on in_valid_i while in_stall_o is low; every input transaction gives
// exactly one output transaction, in order, on out_valid_o, held while
// out_stall_i is high. A two-entry command queue separates the front from
// the back, so input keeps flowing while a finished result waits.
// Status, step-back and non-completing samples pass the command queue and the
// output register; reads also pass ST_READ with its registered RAM read, and a
// sample that completes a block passes ST_PREP, ST_DIV (waiting on the serial
// divider, which produces one quotient bit per cycle over SAMPLE_WIDTH + 10
// bits) and ST_LOG. Status, step-back and non-completing samples sustain one
// per cycle while out_stall_i is low; a read or logging sample holds the back
// end until its result is registered. Configuration (samples_per_mean,
// last_index, start_after_ms) is to be written on cfg_we_i only while the block
// is idle; the block does not enforce it. Reset clears statistics, pointers
// and the full flag; no clearing pass runs, since a high-water mark marks
// which log entries hold data, and unwritten entries read as the marker value.
`default_nettype none

module block_mean_ring_logger #(
  parameter int LOG_DEPTH    = bmrl_pkg::DEFAULT_LOG_DEPTH,
  parameter int SAMPLE_WIDTH = bmrl_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration port.
  input  wire logic                               cfg_we_i,
  input  wire logic [bmrl_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [bmrl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Input channel.
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic [bmrl_pkg::MODE_W-1:0]        mode_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_i,
  input  wire logic [bmrl_pkg::TIME_W-1:0]        now_ms_i,
  input  wire logic [bmrl_pkg::TIME_W-1:0]        elapsed_ms_i,
  input  wire logic [bmrl_pkg::IDX_W-1:0]         index_i,
  // Output channel.
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic                               logged_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     mean_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     lowest_mean_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     highest_mean_o,
  output      logic [bmrl_pkg::IDX_W-1:0]         write_index_o,
  output      logic                               ring_full_o,
  output      logic [bmrl_pkg::IDX_W-1:0]         oldest_index_o,
  output      logic signed [SAMPLE_WIDTH-1:0]     read_value_o,
  output      logic [bmrl_pkg::TIME_W-1:0]        read_time_o,
  output      logic [bmrl_pkg::IDX_W-1:0]         prev_index_o,
  output      logic                               prev_none_o
);

  bmrl_pkg::cfg_t                 cfg_q;
  logic                           cmd_valid;
  logic                           cmd_pop;
  bmrl_pkg::cmd_t                 cmd;
  logic signed [SAMPLE_WIDTH-1:0] cmd_sample;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_mean <= bmrl_pkg::SPM_RESET;
      cfg_q.last_index       <= bmrl_pkg::LAST_INDEX_RESET;
      cfg_q.start_after_ms   <= bmrl_pkg::START_MS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bmrl_pkg::CFG_SAMPLES_PER_MEAN: begin
          cfg_q.samples_per_mean <= cfg_wdata_i[bmrl_pkg::SPM_W-1:0];
        end
        bmrl_pkg::CFG_LAST_INDEX: begin
          cfg_q.last_index <= cfg_wdata_i[bmrl_pkg::IDX_W-1:0];
        end
        bmrl_pkg::CFG_START_AFTER_MS: begin
          cfg_q.start_after_ms <= cfg_wdata_i[bmrl_pkg::TIME_W-1:0];
        end
        default: ;
      endcase
    end
  end

  bmrl_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .sample_i         (sample_i),
    .now_ms_i         (now_ms_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .index_i          (index_i),
    .start_after_ms_i (cfg_q.start_after_ms),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_sample_o     (cmd_sample),
    .cmd_pop_i        (cmd_pop)
  );

  bmrl_back #(
    .LOG_DEPTH    (LOG_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_sample_i   (cmd_sample),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .logged_o       (logged_o),
    .mean_o         (mean_o),
    .lowest_mean_o  (lowest_mean_o),
    .highest_mean_o (highest_mean_o),
    .write_index_o  (write_index_o),
    .ring_full_o    (ring_full_o),
    .oldest_index_o (oldest_index_o),
    .read_value_o   (read_value_o),
    .read_time_o    (read_time_o),
    .prev_index_o   (prev_index_o),
    .prev_none_o    (prev_none_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_block_mean_ring_logger.sv
// Self-checking testbench for block_mean_ring_logger: directed and random input
// transactions with a scoreboard that predicts every output transaction.
// Depends on bmrl_pkg and the block_mean_ring_logger RTL only.
module tb_block_mean_ring_logger;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = bmrl_pkg::DEFAULT_SAMPLE_WIDTH;
  localparam int LOG_DEPTH   = bmrl_pkg::DEFAULT_LOG_DEPTH;
  localparam int TIME_W      = bmrl_pkg::TIME_W;
  localparam int IDX_W       = bmrl_pkg::IDX_W;
  localparam int SPM_W       = bmrl_pkg::SPM_W;
  localparam int CFG_DATA_W  = bmrl_pkg::CFG_DATA_W;
  localparam int MAX_BLOCK   = bmrl_pkg::MAX_BLOCK;
  localparam int LONG_LAT    = SW + 14;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 48;
  localparam int BIG_BLOCK   = 512;

  localparam longint SMAX_L = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN_L = -SMAX_L - 1;
  localparam logic signed [SW-1:0] S_MAX = SW'(SMAX_L);
  localparam logic signed [SW-1:0] S_MIN = SW'(SMIN_L);

  // One input transaction.
  typedef struct {
    bmrl_pkg::mode_e          mode;
    logic signed [SW-1:0]     sample;
    logic [TIME_W-1:0]        now_ms;
    logic [TIME_W-1:0]        elapsed_ms;
    logic [IDX_W-1:0]         index;
  } log_item_t;

  // One output transaction.
  typedef struct {
    logic                     logged;
    logic signed [SW-1:0]     mean;
    logic signed [SW-1:0]     lowest;
    logic signed [SW-1:0]     highest;
    logic [IDX_W-1:0]         write_index;
    logic                     full;
    logic [IDX_W-1:0]         oldest;
    logic signed [SW-1:0]     read_value;
    logic [TIME_W-1:0]        read_time;
    logic [IDX_W-1:0]         prev_index;
    logic                     prev_none;
  } log_result_t;

  // Scoreboard: keeps a private copy of the logger state and configuration,
  // predicts one result per accepted input and checks results in order.
  class ring_log_scoreboard;
    int unsigned          errors;
    int unsigned          results_seen;
    log_result_t          expected_q[$];

    logic [SPM_W-1:0]     spm;
    logic [IDX_W-1:0]     last_idx;
    logic [TIME_W-1:0]    start_ms;

    longint               block_sum;
    int unsigned          block_count;
    longint               min_mean;
    longint               max_mean;
    longint               last_mean;
    int unsigned          write_ptr;
    bit                   full;
    int unsigned          oldest_ptr;
    logic signed [SW-1:0] value_mem[LOG_DEPTH];
    logic [TIME_W-1:0]    time_mem[LOG_DEPTH];

    function new();
      errors       = 0;
      results_seen = 0;
      spm          = bmrl_pkg::SPM_RESET;
      last_idx     = bmrl_pkg::LAST_INDEX_RESET;
      start_ms     = bmrl_pkg::START_MS_RESET;
      block_sum    = 0;
      block_count  = 0;
      min_mean     = SMAX_L;
      max_mean     = SMIN_L;
      last_mean    = 0;
      write_ptr    = 0;
      full         = 1'b0;
      oldest_ptr   = 0;
      // Entries never written read back as the marker value.
      for (int i = 0; i < LOG_DEPTH; i++) begin
        value_mem[i] = S_MAX;
        time_mem[i]  = '0;
      end
    endfunction

    function void set_config(int unsigned n, int unsigned last, logic [TIME_W-1:0] start);
      spm      = SPM_W'(n);
      last_idx = IDX_W'(last);
      start_ms = start;
    endfunction

    function int unsigned ring_last();
      return (last_idx >= LOG_DEPTH) ? LOG_DEPTH - 1 : last_idx;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predict the result of one accepted input transaction.
    function void note_input(log_item_t it);
      log_result_t r;
      longint      m;
      int unsigned n;
      r = '{default: '0};
      case (it.mode)
        bmrl_pkg::MODE_SAMPLE: begin
          if (it.now_ms >= start_ms) begin
            block_sum += longint'(it.sample);
            block_count++;
            // A zero block length acts as one; lengths are capped at the maximum.
            n = (spm == 0) ? 1 : ((spm > MAX_BLOCK) ? MAX_BLOCK : spm);
            if (block_count >= n) begin
              m = block_sum / longint'(n);
              if (m > SMAX_L) m = SMAX_L;
              if (m < SMIN_L) m = SMIN_L;
              last_mean = m;
              if (m > max_mean) max_mean = m;
              if (m < min_mean) min_mean = m;
              if (write_ptr < LOG_DEPTH) begin
                value_mem[write_ptr] = SW'(m);
                time_mem[write_ptr]  = it.elapsed_ms;
              end
              write_ptr++;
              if (write_ptr > ring_last()) begin
                full      = 1'b1;
                write_ptr = 0;
              end
              if (full) oldest_ptr = (write_ptr == 0) ? ring_last() : write_ptr - 1;
              else oldest_ptr = 0;
              block_count = 0;
              block_sum   = 0;
              r.logged    = 1'b1;
            end
          end
        end
        bmrl_pkg::MODE_READ: begin
          if (it.index < LOG_DEPTH) begin
            r.read_value = value_mem[it.index];
            r.read_time  = time_mem[it.index];
          end else begin
            r.read_value = S_MAX;
          end
        end
        bmrl_pkg::MODE_STEP: begin
          if (it.index > 0) r.prev_index = it.index - 1'b1;
          else if (full) r.prev_index = IDX_W'(ring_last());
          else r.prev_none = 1'b1;
        end
        default: ;
      endcase
      r.mean        = SW'(last_mean);
      r.lowest      = SW'(min_mean);
      r.highest     = SW'(max_mean);
      r.write_index = IDX_W'(write_ptr);
      r.full        = full;
      r.oldest      = IDX_W'(oldest_ptr);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("result %0d: %s mismatch, got %0h, expected %0h",
               results_seen, what, got, want);
    endtask

    task check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    // Compare one output transaction with the oldest prediction.
    task check_result(log_result_t got);
      log_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 64'd1, 64'd0);
        return;
      end
      want = expected_q.pop_front();
      check_field("logged", got.logged, want.logged);
      check_field("mean", got.mean, want.mean);
      check_field("lowest_mean", got.lowest, want.lowest);
      check_field("highest_mean", got.highest, want.highest);
      check_field("write_index", got.write_index, want.write_index);
      check_field("ring_full", got.full, want.full);
      check_field("oldest_index", got.oldest, want.oldest);
      check_field("read_value", got.read_value, want.read_value);
      check_field("read_time", got.read_time, want.read_time);
      check_field("prev_index", got.prev_index, want.prev_index);
      check_field("prev_none", got.prev_none, want.prev_none);
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  bmrl_pkg::cfg_e           cfg_addr_i;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  bmrl_pkg::mode_e          mode_i;
  logic signed [SW-1:0]     sample_i;
  logic [TIME_W-1:0]        now_ms_i;
  logic [TIME_W-1:0]        elapsed_ms_i;
  logic [IDX_W-1:0]         index_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     logged_o;
  logic signed [SW-1:0]     mean_o;
  logic signed [SW-1:0]     lowest_mean_o;
  logic signed [SW-1:0]     highest_mean_o;
  logic [IDX_W-1:0]         write_index_o;
  logic                     ring_full_o;
  logic [IDX_W-1:0]         oldest_index_o;
  logic signed [SW-1:0]     read_value_o;
  logic [TIME_W-1:0]        read_time_o;
  logic [IDX_W-1:0]         prev_index_o;
  logic                     prev_none_o;

  ring_log_scoreboard       sb = new();
  bit                       idle_on = 1'b1;
  int unsigned              stall_left = 0;
  int unsigned              cycle_count = 0;

  block_mean_ring_logger #(
    .LOG_DEPTH   (LOG_DEPTH),
    .SAMPLE_WIDTH(SW)
  ) u_top (.*);

  always #5ns clk_i = ~clk_i;

  // Stall the output side in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every accepted output transaction.
  always @(posedge clk_i) begin : take_result
    log_result_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r = '{logged_o, mean_o, lowest_mean_o, highest_mean_o, write_index_o, ring_full_o,
            oldest_index_o, read_value_o, read_time_o, prev_index_o, prev_none_o};
      sb.check_result(r);
    end
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_block_mean_ring_logger failed");
      $finish;
    end
  end

  // Drive one input transaction and wait until it is accepted. Returns in the
  // time step of acceptance with valid still high.
  task automatic send(log_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= it.mode;
    sample_i     <= it.sample;
    now_ms_i     <= it.now_ms;
    elapsed_ms_i <= it.elapsed_ms;
    index_i      <= it.index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  // Drain the block, then write all three registers back to back.
  task automatic write_config(int unsigned n, int unsigned last, logic [TIME_W-1:0] start);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= bmrl_pkg::CFG_SAMPLES_PER_MEAN;
    cfg_wdata_i <= CFG_DATA_W'(n);
    @(posedge clk_i);
    cfg_addr_i  <= bmrl_pkg::CFG_LAST_INDEX;
    cfg_wdata_i <= CFG_DATA_W'(last);
    @(posedge clk_i);
    cfg_addr_i  <= bmrl_pkg::CFG_START_AFTER_MS;
    cfg_wdata_i <= start;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(n, last, start);
  endtask

  initial begin
    int unsigned       ph_spm[N_PHASES];
    int unsigned       ph_last[N_PHASES];
    logic [TIME_W-1:0] ph_start[N_PHASES];
    log_item_t         it;
    int unsigned       pick;

    ph_spm   = '{1, 2, 0, 3, 7, 1, 16, 2};
    ph_last  = '{7, 0, 1023, 5, 63, 2, 15, 999};
    ph_start = '{0, 1000, 0, 32'hFFFF_FFFF, $urandom, 0, 50000, 0};

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_addr_i   <= bmrl_pkg::CFG_SAMPLES_PER_MEAN;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    mode_i       <= bmrl_pkg::MODE_SAMPLE;
    sample_i     <= '0;
    now_ms_i     <= '0;
    elapsed_ms_i <= '0;
    index_i      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset configuration: unwritten entries, step back
    // on an empty ring, the unused mode and the sample extremes.
    send('{bmrl_pkg::MODE_READ, '0, '0, '0, 10'd0});
    send('{bmrl_pkg::MODE_READ, '0, '0, '0, 10'd1023});
    send('{bmrl_pkg::MODE_STEP, '0, '0, '0, 10'd0});
    send('{bmrl_pkg::MODE_STEP, '0, '0, '0, 10'd1023});
    send('{bmrl_pkg::MODE_UNUSED, S_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023});
    send('{bmrl_pkg::MODE_SAMPLE, S_MAX, 32'd0, 32'hFFFF_FFFF, 10'd0});
    send('{bmrl_pkg::MODE_SAMPLE, S_MIN, 32'hFFFF_FFFF, 32'd0, 10'd0});
    send('{bmrl_pkg::MODE_SAMPLE, -24'sd1, 32'd7, 32'd12345, 10'd0});
    send('{bmrl_pkg::MODE_READ, '0, '0, '0, 10'd0});
    send('{bmrl_pkg::MODE_READ, '0, '0, '0, 10'd1});

    // Zero block length, start delay, and last index lowered below the pointer.
    write_config(0, 1, 100);
    send('{bmrl_pkg::MODE_SAMPLE, 24'sd9, 32'd99, 32'd1, 10'd0});
    send('{bmrl_pkg::MODE_SAMPLE, 24'sd5, 32'd100, 32'd2, 10'd0});
    send('{bmrl_pkg::MODE_STEP, '0, '0, '0, 10'd0});
    send('{bmrl_pkg::MODE_SAMPLE, 24'sd6, 32'hFFFF_FFFF, 32'd3, 10'd0});
    send('{bmrl_pkg::MODE_READ, '0, '0, '0, 10'd3});

    // Block length lowered in mid-block saturates the mean both ways.
    write_config(4, 1023, 0);
    repeat (3) send('{bmrl_pkg::MODE_SAMPLE, S_MAX, 32'd5, 32'd4, 10'd0});
    write_config(1, 1023, 0);
    send('{bmrl_pkg::MODE_SAMPLE, S_MAX, 32'd5, 32'd5, 10'd0});
    write_config(4, 1023, 0);
    repeat (3) send('{bmrl_pkg::MODE_SAMPLE, S_MIN, 32'd5, 32'd6, 10'd0});
    write_config(2, 1023, 0);
    send('{bmrl_pkg::MODE_SAMPLE, S_MIN, 32'd5, 32'd7, 10'd0});

    // Negative sums truncate toward zero.
    write_config(3, 1023, 0);
    send('{bmrl_pkg::MODE_SAMPLE, -24'sd1, 32'd5, 32'd8, 10'd0});
    send('{bmrl_pkg::MODE_SAMPLE, -24'sd1, 32'd5, 32'd9, 10'd0});
    send('{bmrl_pkg::MODE_SAMPLE, 24'sd0, 32'd5, 32'd10, 10'd0});

    // An oversized block length acts as the maximum, so nothing is logged
    // early; the block is then closed by a shorter length, with a running sum
    // beyond the signed 32-bit range.
    write_config(2047, 1023, 0);
    for (int i = 0; i < BIG_BLOCK; i++) begin
      if (i == BIG_BLOCK - 1) write_config(BIG_BLOCK, 1023, 0);
      it.mode       = bmrl_pkg::MODE_SAMPLE;
      it.sample     = S_MAX - SW'($urandom_range(0, 4095));
      it.now_ms     = $urandom;
      it.elapsed_ms = $urandom;
      it.index      = IDX_W'($urandom);
      send(it);
    end

    // Random phases, each with its own configuration.
    for (int p = 0; p < N_PHASES; p++) begin
      write_config(ph_spm[p], ph_last[p], ph_start[p]);
      idle_on = (p != 2) && (p != N_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick          = $urandom_range(0, 19);
        it.mode       = (pick < 12) ? bmrl_pkg::MODE_SAMPLE :
                        (pick < 16) ? bmrl_pkg::MODE_READ :
                        (pick < 19) ? bmrl_pkg::MODE_STEP : bmrl_pkg::MODE_UNUSED;
        it.elapsed_ms = $urandom;
        it.sample     = SW'($urandom);
        case ($urandom_range(0, 15))
          0: it.sample = S_MAX;
          1: it.sample = S_MIN;
          2: it.sample = '0;
          3: it.sample = '1;
          default: ;
        endcase
        if (ph_start[p] != 0 && $urandom_range(0, 4) == 0)
          it.now_ms = $urandom_range(ph_start[p] - 1, 0);
        else
          it.now_ms = $urandom_range(32'hFFFF_FFFF, ph_start[p]);
        case ($urandom_range(0, 5))
          0: it.index = '0;
          1: it.index = IDX_W'($urandom);
          default: it.index = IDX_W'($urandom_range(ph_last[p], 0));
        endcase
        send(it);
      end
    end

    // Let the last results drain, then allow time for any stray transaction.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * LONG_LAT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_block_mean_ring_logger passed");
    end else begin
      $display("tb_block_mean_ring_logger failed");
    end
    $finish;
  end

endmodule
